// ----- hdl/eftd_pkg.sv -----
// ----------------------------------------------------------------------------
// eftd_pkg
// Shared widths, types and constants of the earliest-free task dispatcher.
// ----------------------------------------------------------------------------
package eftd_pkg;

  localparam int MAX_WORKERS_DEF = 8;
  localparam int WIDX_W          = 6;
  localparam int DUR_W           = 16;
  localparam int ELAPSED_W       = 32;
  localparam int WCNT_W          = 4;
  localparam int WOUT_W          = 4;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic [ELAPSED_W-1:0] ELAPSED_SAT = {ELAPSED_W{1'b1}};
  localparam logic [DUR_W-1:0]     DUR_ALL1    = {DUR_W{1'b1}};
  localparam logic [WCNT_W-1:0]    WCNT_RESET  = WCNT_W'(8);

  typedef enum logic {
    REG_WORKER_COUNT    = 1'b0,
    REG_MASTER_RESERVED = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic              vld;
    logic              found;
    logic [WIDX_W-1:0] idle_idx;
    logic [DUR_W-1:0]  min_val;
    logic [WIDX_W-1:0] min_idx;
    logic [DUR_W-1:0]  max_val;
  } tok_t;

  typedef struct packed {
    logic              load_en;
    logic [WIDX_W-1:0] load_idx;
    logic [DUR_W-1:0]  load_val;
    logic              sub_en;
    logic [DUR_W-1:0]  sub_val;
    logic              clr;
  } cell_cmd_t;

  localparam tok_t TOK_INIT = '{
    vld:      1'b1,
    found:    1'b0,
    idle_idx: '0,
    min_val:  DUR_ALL1,
    min_idx:  '0,
    max_val:  '0
  };

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_SPAN0  = 5'b00100,
    ST_SPAN   = 5'b01000,
    ST_RESULT = 5'b10000
  } state_e;

endpackage

// ----- hdl/task_req_if.sv -----
// ----------------------------------------------------------------------------
// task_req_if
// Task request channel: duration and end-of-batch mark.
// ----------------------------------------------------------------------------
interface task_req_if import eftd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DUR_W-1:0] task_duration;
  logic             last_task;

  modport source (output valid, output task_duration, output last_task, input ready);
  modport sink   (input valid, input task_duration, input last_task, output ready);
endinterface

// ----- hdl/task_rsp_if.sv -----
// ----------------------------------------------------------------------------
// task_rsp_if
// Dispatch result channel: chosen worker, makespan and end-of-batch mark.
// ----------------------------------------------------------------------------
interface task_rsp_if import eftd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [WOUT_W-1:0]    worker_index;
  logic [ELAPSED_W-1:0] makespan;
  logic                 is_last;

  modport source (output valid, output worker_index, output makespan, output is_last,
                  input ready);
  modport sink   (input valid, input worker_index, input makespan, input is_last,
                  output ready);
endinterface

// ----- hdl/eftd_cell.sv -----
// ----------------------------------------------------------------------------
// eftd_cell
// One worker: holds its remaining time and updates the token passing through.
// ----------------------------------------------------------------------------
module eftd_cell import eftd_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      active_i,
  input  cell_cmd_t cmd_i,
  input  tok_t      tok_i,
  output tok_t      tok_o
);

  localparam logic [WIDX_W-1:0] MyIdx = WIDX_W'(IDX);

  logic [DUR_W-1:0] rt_q, rt_d;
  tok_t             tok_q, tok_d;

  always_comb begin
    rt_d = rt_q;
    if (cmd_i.clr) begin
      rt_d = '0;
    end else if (cmd_i.load_en && (cmd_i.load_idx == MyIdx)) begin
      rt_d = cmd_i.load_val;
    end else if (cmd_i.sub_en && active_i) begin
      rt_d = rt_q - cmd_i.sub_val;
    end
  end

  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld && active_i) begin
      if (!tok_i.found && (rt_q == '0)) begin
        tok_d.found    = 1'b1;
        tok_d.idle_idx = MyIdx;
      end
      if (rt_q < tok_i.min_val) begin
        tok_d.min_val = rt_q;
        tok_d.min_idx = MyIdx;
      end
      if (rt_q > tok_i.max_val) begin
        tok_d.max_val = rt_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_q  <= '0;
      tok_q <= '0;
    end else begin
      rt_q  <= rt_d;
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ----- hdl/eftd_ctrl.sv -----
// ----------------------------------------------------------------------------
// eftd_ctrl
// Sequencer: launches tokens, applies the advance and dispatch, holds results.
// ----------------------------------------------------------------------------
module eftd_ctrl import eftd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  task_req_if.sink   req,
  task_rsp_if.source rsp,
  input  logic       master_i,
  input  tok_t       tail_i,
  output tok_t       inj_o,
  output cell_cmd_t  cmd_o
);

  state_e               state_q, state_d;
  logic [DUR_W-1:0]     dur_q, dur_d;
  logic                 last_q, last_d;
  logic [WIDX_W-1:0]    w_q, w_d;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic [ELAPSED_W-1:0] span_q, span_d;
  logic                 ovld_q, ovld_d;
  logic [WOUT_W-1:0]    oidx_q, oidx_d;
  logic [ELAPSED_W-1:0] ospan_q, ospan_d;
  logic                 olast_q, olast_d;
  logic [ELAPSED_W:0]   sum_min, sum_max;
  logic [WIDX_W:0]      idx_ofs;
  logic                 req_fire;

  assign req.ready = (state_q == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign sum_min   = {1'b0, elapsed_q} + {{(ELAPSED_W+1-DUR_W){1'b0}}, tail_i.min_val};
  assign sum_max   = {1'b0, elapsed_q} + {{(ELAPSED_W+1-DUR_W){1'b0}}, tail_i.max_val};
  assign idx_ofs   = {1'b0, w_q} + {{WIDX_W{1'b0}}, master_i};

  always_comb begin
    state_d   = state_q;
    dur_d     = dur_q;
    last_d    = last_q;
    w_d       = w_q;
    elapsed_d = elapsed_q;
    span_d    = span_q;
    ovld_d    = ovld_q && !rsp.ready;
    oidx_d    = oidx_q;
    ospan_d   = ospan_q;
    olast_d   = olast_q;
    inj_o     = '0;
    cmd_o     = '0;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          dur_d   = req.task_duration;
          last_d  = req.last_task;
          inj_o   = TOK_INIT;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tail_i.vld) begin
          w_d            = tail_i.found ? tail_i.idle_idx : tail_i.min_idx;
          cmd_o.load_en  = 1'b1;
          cmd_o.load_idx = w_d;
          cmd_o.load_val = dur_q;
          if (!tail_i.found) begin
            cmd_o.sub_en = 1'b1;
            cmd_o.sub_val = tail_i.min_val;
            elapsed_d = sum_min[ELAPSED_W] ? ELAPSED_SAT : sum_min[ELAPSED_W-1:0];
          end
          span_d  = '0;
          state_d = last_q ? ST_SPAN0 : ST_RESULT;
        end
      end
      ST_SPAN0: begin
        inj_o   = TOK_INIT;
        state_d = ST_SPAN;
      end
      ST_SPAN: begin
        if (tail_i.vld) begin
          span_d    = sum_max[ELAPSED_W] ? ELAPSED_SAT : sum_max[ELAPSED_W-1:0];
          cmd_o.clr = 1'b1;
          elapsed_d = '0;
          state_d   = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!ovld_q || rsp.ready) begin
          ovld_d  = 1'b1;
          oidx_d  = idx_ofs[WOUT_W-1:0];
          ospan_d = span_q;
          olast_d = last_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      elapsed_q <= '0;
      ovld_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      elapsed_q <= elapsed_d;
      ovld_q    <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dur_q   <= dur_d;
    last_q  <= last_d;
    w_q     <= w_d;
    span_q  <= span_d;
    oidx_q  <= oidx_d;
    ospan_q <= ospan_d;
    olast_q <= olast_d;
  end

  assign rsp.valid        = ovld_q;
  assign rsp.worker_index = oidx_q;
  assign rsp.makespan     = ospan_q;
  assign rsp.is_last      = olast_q;

  a_tail_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_i.vld |-> (state_q == ST_SCAN || state_q == ST_SPAN))
    else $error("token left the chain outside a pass");

  a_load_clr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load_en && cmd_o.clr))
    else $error("dispatch and clear in the same cycle");

  a_clear_elapsed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SPAN && tail_i.vld) |=> (elapsed_q == '0))
    else $error("elapsed time not cleared at end of batch");

  a_rsp_from_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovld_q) |-> $past(state_q == ST_RESULT))
    else $error("request result loaded outside result state");

endmodule

// ----- hdl/earliest_free_task_dispatcher.sv -----
// ----------------------------------------------------------------------------
// earliest_free_task_dispatcher
// Dispatches each task to the lowest-numbered idle worker, advancing time to
// the earliest finish when all workers are busy; reports makespan per batch.
//
//   channel    dir  handshake        payload
//   task_req_i in   valid/ready      task_duration[15:0], last_task
//   task_rsp_o out  valid/ready      worker_index[3:0], makespan[31:0], is_last
//   apb        in   psel/penable     paddr[2:0], pwdata/prdata[31:0], pready=1
//
// One request at a time: a token walks the row of MAX_WORKERS cells, one cell
// a cycle. The result is registered once the token leaves the last cell, and
// the next request is taken only after the result state; on the last task
// of a batch a second walk gathers the largest remaining time before the
// result is loaded and the controller returns to idle for the next request.
// Reset clears all remaining times and elapsed time at once; no clearing pass.
// A stalled result waits in the output register while the next request runs;
// that request then holds in its result state until the register drains.
// ----------------------------------------------------------------------------
module earliest_free_task_dispatcher import eftd_pkg::*; #(
  parameter int MAX_WORKERS = MAX_WORKERS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  task_req_if.sink              task_req_i,
  task_rsp_if.source            task_rsp_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [WCNT_W-1:0]      wcnt_q, wcnt_d;
  logic                   master_q, master_d;
  logic [WCNT_W-1:0]      n_active;
  logic [MAX_WORKERS-1:0] active;
  logic                   cfg_wr;
  cfg_reg_e               cfg_sel;
  tok_t                   tok [MAX_WORKERS+1];
  cell_cmd_t              cmd;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_e'(paddr[2]);

  always_comb begin
    wcnt_d   = wcnt_q;
    master_d = master_q;
    if (cfg_wr) begin
      case (cfg_sel)
        REG_WORKER_COUNT:    wcnt_d   = pwdata[WCNT_W-1:0];
        REG_MASTER_RESERVED: master_d = pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_WORKER_COUNT:    prdata = {{(CFG_DATA_W-WCNT_W){1'b0}}, wcnt_q};
      REG_MASTER_RESERVED: prdata = {{(CFG_DATA_W-1){1'b0}}, master_q};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcnt_q   <= WCNT_RESET;
      master_q <= 1'b0;
    end else begin
      wcnt_q   <= wcnt_d;
      master_q <= master_d;
    end
  end

  always_comb begin
    if (wcnt_q == '0) begin
      n_active = WCNT_W'(1);
    end else if (32'(wcnt_q) > 32'(MAX_WORKERS)) begin
      n_active = WCNT_W'(MAX_WORKERS);
    end else begin
      n_active = wcnt_q;
    end
  end

  eftd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req      (task_req_i),
    .rsp      (task_rsp_o),
    .master_i (master_q),
    .tail_i   (tok[MAX_WORKERS]),
    .inj_o    (tok[0]),
    .cmd_o    (cmd)
  );

  for (genvar g = 0; g < MAX_WORKERS; g++) begin : g_cell
    assign active[g] = (32'(g) < 32'(n_active));

    eftd_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .active_i (active[g]),
      .cmd_i    (cmd),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1])
    );
  end

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the earliest-free task dispatcher. Task requests go
// in over the request channel and dispatch results come back on the result
// channel. A local copy of the worker timers and the elapsed clock predicts
// each result, and every result is compared field by field in arrival order.
// Registers are reached over the APB port between phases and read back. The
// phases cover reset values, directed corner cases, workers left out of the
// active set, a run of longest tasks on a single worker, and random batches
// under random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import eftd_pkg::*;

  localparam int  NWORK        = MAX_WORKERS_DEF;
  localparam int  LIMIT_CYCLES = 4_000_000;
  localparam int  DRAIN_CYCLES = 2 * NWORK + 8;
  localparam int  MAX_REPORTS  = 100;

  typedef struct packed {
    logic [WOUT_W-1:0]    worker_index;
    logic [ELAPSED_W-1:0] makespan;
    logic                 is_last;
  } dispatch_t;

  logic clk_i;
  logic rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  task_req_if req_if ();
  task_rsp_if rsp_if ();

  earliest_free_task_dispatcher dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .task_req_i (req_if),
    .task_rsp_o (rsp_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // worker timers, elapsed clock and register copies
  logic [DUR_W-1:0]     worker_left [NWORK];
  logic [ELAPSED_W-1:0] clock_now;
  logic [WCNT_W-1:0]    cfg_workers;
  logic                 cfg_master;

  dispatch_t pending_dispatch [$];

  int  err_count;
  int  requests_sent;
  int  results_seen;
  int  batches_seen;
  int  reg_writes;
  int  cycle_count;
  bit  no_idle;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: run limit reached with %0d results outstanding", $realtime,
               pending_dispatch.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [ELAPSED_W-1:0] sat_sum(logic [ELAPSED_W-1:0] a,
                                                   logic [ELAPSED_W-1:0] b);
    logic [ELAPSED_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ELAPSED_W] ? ELAPSED_SAT : s[ELAPSED_W-1:0];
  endfunction

  function automatic void clear_timers();
    for (int i = 0; i < NWORK; i++) worker_left[i] = '0;
    clock_now = '0;
  endfunction

  function automatic int first_free(int n);
    for (int i = 0; i < n; i++)
      if (worker_left[i] == '0) return i;
    return -1;
  endfunction

  function automatic dispatch_t dispatch_task(logic [DUR_W-1:0] dur, logic last);
    int               n;
    int               w;
    logic [DUR_W-1:0] lo;
    logic [DUR_W-1:0] hi;
    dispatch_t        r;
    n = int'(cfg_workers);
    if (n == 0) n = 1;
    if (n > NWORK) n = NWORK;
    w = first_free(n);
    if (w < 0) begin
      lo = DUR_ALL1;
      for (int i = 0; i < n; i++)
        if (worker_left[i] < lo) lo = worker_left[i];
      clock_now = sat_sum(clock_now, ELAPSED_W'(lo));
      for (int i = 0; i < n; i++) worker_left[i] = worker_left[i] - lo;
      w = first_free(n);
      if (w < 0) w = 0;
    end
    worker_left[w] = dur;
    r.makespan = '0;
    if (last) begin
      hi = '0;
      for (int i = 0; i < n; i++)
        if (worker_left[i] > hi) hi = worker_left[i];
      r.makespan = sat_sum(clock_now, ELAPSED_W'(hi));
      clear_timers();
    end
    r.worker_index = WOUT_W'(w + int'(cfg_master));
    r.is_last = last;
    return r;
  endfunction

  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DUR_ALL1;
      2, 3, 4: return DUR_W'($urandom_range(1, 8));
      5:       return DUR_W'($urandom_range(0, 255));
      default: return DUR_W'($urandom);
    endcase
  endfunction

  task automatic send_task(logic [DUR_W-1:0] dur, logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.task_duration <= dur;
    req_if.last_task     <= last;
    do @(posedge clk_i); while (!req_if.ready);
    pending_dispatch = {pending_dispatch, dispatch_task(dur, last)};
    requests_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_dispatch.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(cfg_reg_e r, logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(int'(r) * 4);
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (r == REG_WORKER_COUNT) cfg_workers = value[WCNT_W-1:0];
    else                       cfg_master  = value[0];
    reg_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_check(cfg_reg_e r);
    logic [CFG_DATA_W-1:0] want;
    want = (r == REG_WORKER_COUNT) ? CFG_DATA_W'(cfg_workers) : CFG_DATA_W'(cfg_master);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_ADDR_W'(int'(r) * 4);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      err_count++;
      $display("%0t: register %s read expected %0h actual %0h", $realtime, r.name(),
               want, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(logic [CFG_DATA_W-1:0] workers, logic [CFG_DATA_W-1:0] master);
    reg_write(REG_WORKER_COUNT, workers);
    reg_write(REG_MASTER_RESERVED, master);
    reg_check(REG_WORKER_COUNT);
    reg_check(REG_MASTER_RESERVED);
  endtask

  // result side: draw a stall for every result, then accept it
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      @(negedge clk_i);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  always @(posedge clk_i) begin
    dispatch_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      if (rsp_if.is_last === 1'b1) batches_seen++;
      if (pending_dispatch.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t: unexpected result worker %0d makespan %0d", $realtime,
                   rsp_if.worker_index, rsp_if.makespan);
      end else begin
        want = pending_dispatch.pop_front();
        if (rsp_if.worker_index !== want.worker_index) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: worker_index expected %0d actual %0d", $realtime,
                     want.worker_index, rsp_if.worker_index);
        end
        if (rsp_if.makespan !== want.makespan) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: makespan expected %0d actual %0d", $realtime,
                     want.makespan, rsp_if.makespan);
        end
        if (rsp_if.is_last !== want.is_last) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: is_last expected %0d actual %0d", $realtime,
                     want.is_last, rsp_if.is_last);
        end
      end
    end
  end

  task automatic test_register_access();
    reg_check(REG_WORKER_COUNT);
    reg_check(REG_MASTER_RESERVED);
    set_config(32'hFFFF_FFF0, 32'hFFFF_FFFF);
    set_config(32'h0000_000F, 32'h0000_0000);
    set_config(32'd8, 32'd0);
  endtask

  task automatic test_directed_dispatch();
    // fill all eight, force an advance, keep a zero-length worker idle
    for (int i = 0; i < NWORK; i++) send_task(DUR_ALL1, 1'b0);
    send_task('0, 1'b0);
    send_task('0, 1'b0);
    send_task(16'd1, 1'b0);
    send_task(DUR_ALL1, 1'b1);
    send_task('0, 1'b1);
    wait_drained();
    // zero count acts as one worker, with the master offset
    set_config(32'd0, 32'd1);
    send_task(16'd5, 1'b0);
    send_task(16'd3, 1'b0);
    send_task('0, 1'b1);
    wait_drained();
    // count above the maximum saturates; top worker reports as index eight
    set_config(32'd15, 32'd1);
    for (int i = 0; i < NWORK; i++) send_task(16'(i + 1), 1'b0);
    send_task(16'h8000, 1'b1);
    wait_drained();
  endtask

  task automatic test_inactive_workers();
    set_config(32'd8, 32'd0);
    for (int i = 0; i < NWORK; i++) send_task(16'(100 * (i + 1)), 1'b0);
    wait_drained();
    set_config(32'd2, 32'd0);
    send_task(16'd7, 1'b0);
    send_task(16'd9, 1'b0);
    send_task(16'd4, 1'b0);
    wait_drained();
    set_config(32'd8, 32'd1);
    send_task(16'd1, 1'b0);
    send_task(16'd2, 1'b0);
    send_task(16'd3, 1'b1);
    wait_drained();
  endtask

  task automatic test_long_tasks();
    // one worker, longest tasks back to back: the elapsed clock grows large
    set_config(32'd1, 32'd0);
    no_idle = 1'b1;
    for (int k = 0; k < 64; k++) send_task(DUR_ALL1, 1'b0);
    send_task(DUR_ALL1, 1'b1);
    wait_drained();
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic(int phases, int per_phase);
    int          left_in_batch;
    logic [31:0] workers;
    logic [31:0] master;
    for (int p = 0; p < phases; p++) begin
      case (p)
        0:       begin workers = 32'd1;  master = 32'd0; end
        1:       begin workers = 32'd8;  master = 32'd1; end
        2:       begin workers = 32'd0;  master = 32'd0; end
        3:       begin workers = 32'd15; master = 32'd1; end
        default: begin workers = $urandom; master = $urandom; end
      endcase
      set_config(workers, master);
      no_idle = (p == 2) || (p == 5);
      left_in_batch = $urandom_range(1, 24);
      for (int k = 0; k < per_phase; k++) begin
        left_in_batch--;
        if (left_in_batch == 0 || $urandom_range(0, 39) == 0) begin
          send_task(pick_duration(), 1'b1);
          left_in_batch = $urandom_range(1, 24);
        end else begin
          send_task(pick_duration(), 1'b0);
        end
      end
      wait_drained();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    err_count     = 0;
    requests_sent = 0;
    results_seen  = 0;
    batches_seen  = 0;
    reg_writes    = 0;
    no_idle       = 1'b0;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    req_if.valid         = 1'b0;
    req_if.task_duration = '0;
    req_if.last_task     = 1'b0;
    rsp_if.ready         = 1'b0;
    clear_timers();
    cfg_workers = WCNT_RESET;
    cfg_master  = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_register_access();
    test_directed_dispatch();
    test_inactive_workers();
    test_long_tasks();
    test_random_traffic(8, 110);

    $display("Covered %0d task requests, %0d results in %0d batches, %0d register writes,",
             requests_sent, results_seen, batches_seen, reg_writes);
    $display("with worker counts 0 to 15, master offset on and off, and long single-worker runs.");
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", err_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
